// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the converter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, off while in reset
`define ASSERT_CLKD(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// implication checked on every rising edge of clk, off while in reset
`define ASSERT_IMPL(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/t2u_pkg.sv =====
// package with types, constants and character helpers for the text to unsigned converter
package t2u_pkg;

    localparam int OUT_VALUE_BITS = 64;
    localparam int BASE_BITS      = 6;
    localparam int STATUS_BITS    = 2;
    localparam int IN_DATA_BITS   = 8;
    localparam int OUT_DATA_BITS  = 72;

    typedef logic [BASE_BITS-1:0]   base_t;
    typedef logic [STATUS_BITS-1:0] status_t;
    typedef logic [7:0]             char_t;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGN,
        PH_PREFIX,
        PH_PREFIX_X,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    localparam status_t STAT_OK       = 2'd0;
    localparam status_t STAT_RANGE    = 2'd1;
    localparam status_t STAT_BAD_BASE = 2'd2;
    localparam status_t STAT_UNUSED   = 2'd3;

    localparam base_t MAX_BASE     = 6'd36;
    localparam base_t RADIX_RESET  = 6'd10;
    localparam base_t BASE_AUTO    = 6'd0;
    localparam base_t BASE_OCT     = 6'd8;
    localparam base_t BASE_DEC     = 6'd10;
    localparam base_t BASE_HEX     = 6'd16;
    localparam base_t NO_DIGIT     = 6'd63;

    localparam char_t CH_NUL   = 8'h00;
    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_LF    = 8'h0a;
    localparam char_t CH_VT    = 8'h0b;
    localparam char_t CH_FF    = 8'h0c;
    localparam char_t CH_CR    = 8'h0d;
    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_PLUS  = 8'h2b;
    localparam char_t CH_MINUS = 8'h2d;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_NINE  = 8'h39;
    localparam char_t CH_UP_A  = 8'h41;
    localparam char_t CH_UP_X  = 8'h58;
    localparam char_t CH_UP_Z  = 8'h5a;
    localparam char_t CH_LO_A  = 8'h61;
    localparam char_t CH_LO_X  = 8'h78;
    localparam char_t CH_LO_Z  = 8'h7a;

    function automatic logic is_space(input char_t ch);
        return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) ||
               (ch == CH_CR) || (ch == CH_FF) || (ch == CH_VT);
    endfunction

    function automatic base_t digit_of(input char_t ch);
        char_t d;
        d = char_t'(NO_DIGIT);
        if ((ch >= CH_ZERO) && (ch <= CH_NINE))
        begin
            d = ch - CH_ZERO;
        end
        else if ((ch >= CH_UP_A) && (ch <= CH_UP_Z))
        begin
            d = ch - CH_UP_A + 8'd10;
        end
        else if ((ch >= CH_LO_A) && (ch <= CH_LO_Z))
        begin
            d = ch - CH_LO_A + 8'd10;
        end
        return d[BASE_BITS-1:0];
    endfunction

endpackage

// ===== rtl/core/text_to_unsigned_any_base.sv =====
// text to unsigned converter top level, one character per beat, result on the last beat
`include "assert_macros.svh"

// Takes one character per beat and accepts a new beat every cycle unless the
// slave side stalls, with no gaps between strings. A beat sits in the input
// register while the parse step and one multiply-add of the accumulator by the
// base run as combinational logic; the result of a string is registered on the
// master side when its last beat leaves the input register. A last beat waits
// there while an earlier result is still held on the master side, and the slave
// side stalls behind it. The rate is set by that multiply-add, which feeds the
// accumulator back for the next character.
// tdata out: value in bits 63:0, status in bits 65:64 (0 ok, 1 out of range,
// 2 invalid base). The radix register (reset 10) is written through the cfg
// channel; the user is to write it only between strings, which the block does not enforce.
module text_to_unsigned_any_base #(
    parameter int VALUE_BITS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  t2u_pkg::base_t                       cfg_data,       // radix
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [t2u_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,   // char_byte
    input  logic                                 s_axis_tlast,   // last_char
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [t2u_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata    // value, status, zero pad
);
    import t2u_pkg::*;

    localparam int PROD_BITS = VALUE_BITS + BASE_BITS;

    base_t                 radix_reg;

    logic                  in_valid_reg;
    char_t                 in_char_reg;
    logic                  in_last_reg;
    logic                  advance;

    phase_t                phase_reg,    phase_next;
    logic                  negate_reg,   negate_next;
    logic [VALUE_BITS-1:0] acc_reg,      acc_next;
    base_t                 base_reg,     base_next;
    logic                  ovf_reg,      ovf_next;

    logic                  out_valid_reg;
    logic [OUT_VALUE_BITS-1:0] value_reg, value_next;
    status_t               status_reg,   status_next;

    logic                  stop;
    base_t                 digit;
    base_t                 final_base;
    logic [PROD_BITS-1:0]  prod;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radix_reg <= cfg_data;
        end
    end

    // input register
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // parse step and multiply-add
    assign digit = digit_of(in_char_reg);
    assign prod  = PROD_BITS'(acc_reg) * PROD_BITS'(base_reg) + PROD_BITS'(digit);

    always_comb
    begin
        phase_next  = phase_reg;
        negate_next = negate_reg;
        acc_next    = acc_reg;
        base_next   = base_reg;
        ovf_next    = ovf_reg;
        stop        = 1'b0;

        if (phase_next == PH_SKIP)
        begin
            if (is_space(in_char_reg))
            begin
                stop = 1'b1;
            end
            else
            begin
                base_next = radix_reg;
                if (radix_reg > MAX_BASE)
                begin
                    phase_next = PH_DONE;
                    stop       = 1'b1;
                end
                else
                begin
                    phase_next = PH_SIGN;
                end
            end
        end

        if (!stop && (phase_next == PH_SIGN))
        begin
            phase_next = PH_PREFIX;
            if (in_char_reg == CH_MINUS)
            begin
                negate_next = 1'b1;
                stop        = 1'b1;
            end
            else if (in_char_reg == CH_PLUS)
            begin
                stop = 1'b1;
            end
        end

        if (!stop && (phase_next == PH_PREFIX))
        begin
            if ((base_next == BASE_AUTO) || (base_next == BASE_HEX))
            begin
                if (in_char_reg == CH_ZERO)
                begin
                    if (base_next == BASE_AUTO)
                    begin
                        base_next = BASE_OCT;
                    end
                    phase_next = PH_PREFIX_X;
                    stop       = 1'b1;
                end
                else if (base_next == BASE_AUTO)
                begin
                    base_next = BASE_DEC;
                end
            end
            if (!stop)
            begin
                phase_next = PH_DIGITS;
            end
        end

        if (!stop && (phase_next == PH_PREFIX_X))
        begin
            phase_next = PH_DIGITS;
            if ((in_char_reg == CH_LO_X) || (in_char_reg == CH_UP_X))
            begin
                base_next = BASE_HEX;
                stop      = 1'b1;
            end
        end

        // base_reg equals base_next here except on a digit whose beat also settled the
        // base, so the product below uses base_reg and that case takes the digit alone
        if (!stop && (phase_next == PH_DIGITS))
        begin
            if ((in_char_reg == CH_NUL) || (base_next == BASE_AUTO) || (digit >= base_next))
            begin
                phase_next = PH_DONE;
            end
            else if (base_next != base_reg)
            begin
                // accumulator is still zero when the base was just settled
                acc_next = VALUE_BITS'(digit);
            end
            else if (|prod[PROD_BITS-1:VALUE_BITS])
            begin
                ovf_next   = 1'b1;
                phase_next = PH_DONE;
            end
            else
            begin
                acc_next = prod[VALUE_BITS-1:0];
            end
        end

        // result on the last beat
        final_base = (phase_next == PH_SKIP) ? radix_reg : base_next;
        if (final_base > MAX_BASE)
        begin
            value_next  = OUT_VALUE_BITS'({VALUE_BITS{1'b1}});
            status_next = STAT_BAD_BASE;
        end
        else if (ovf_next)
        begin
            value_next  = OUT_VALUE_BITS'({VALUE_BITS{1'b1}});
            status_next = STAT_RANGE;
        end
        else
        begin
            value_next  = OUT_VALUE_BITS'(negate_next ? (VALUE_BITS'(0) - acc_next) : acc_next);
            status_next = STAT_OK;
        end

        if (in_last_reg)
        begin
            phase_next  = PH_SKIP;
            negate_next = 1'b0;
            acc_next    = '0;
            base_next   = BASE_AUTO;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SKIP;
            negate_reg <= 1'b0;
            acc_reg    <= '0;
            base_reg   <= BASE_AUTO;
            ovf_reg    <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            negate_reg <= negate_next;
            acc_reg    <= acc_next;
            base_reg   <= base_next;
            ovf_reg    <= ovf_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_BITS-OUT_VALUE_BITS-STATUS_BITS){1'b0}},
                            status_reg, value_reg};

    `ASSERT_IMPL(a_empty_ready, !in_valid_reg, s_axis_tready)
    `ASSERT_CLKD(a_last_gives_result, (advance && in_last_reg) |=> out_valid_reg)
    `ASSERT_CLKD(a_last_clears, (advance && in_last_reg) |=> (phase_reg == PH_SKIP && acc_reg == '0))
    `ASSERT_IMPL(a_status_code, out_valid_reg, status_reg != STAT_UNUSED)

endmodule
